/* rtl/key_debounce_event_fifo_defines.svh */
// Assertion macros for the key debounce event FIFO.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef KEY_DEBOUNCE_EVENT_FIFO_DEFINES_SVH
`define KEY_DEBOUNCE_EVENT_FIFO_DEFINES_SVH

// Same-cycle implication.
`define KDEF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KDEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kdef_pkg.sv */
// Shared constants, types and command codes for the key debounce event FIFO.
// No dependencies.
package kdef_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int FIFO_DEPTH  = 16;

  localparam int CMD_W  = 2;
  localparam int PINS_W = 4;
  localparam int CODE_W = 8;
  localparam int FILL_W = 5;
  localparam int DROP_W = 3;
  localparam int TMR_W  = 8;

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = $clog2(FIFO_DEPTH + NUM_BUTTONS);
  localparam int RANK_W = $clog2(NUM_BUTTONS + 1);

  localparam logic [TMR_W-1:0]  TIMEOUT_RST = TMR_W'(1);
  localparam logic [DROP_W-1:0] DROP_MAX    = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIN  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_POP  = 2'd2
  } cmd_e;

  // Events raised by one transaction, one bit per button in ascending order.
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] push;
    logic                   rel;
  } push_req_t;

endpackage

/* rtl/kdef_if.sv */
// Valid/ready channel interfaces for the key debounce event FIFO.
// Depends on kdef_pkg for field widths.
interface kdef_in_if import kdef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [PINS_W-1:0] pins;

  modport source (output valid, output cmd, output pins, input ready);
  modport sink   (input valid, input cmd, input pins, output ready);
endinterface

interface kdef_out_if import kdef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              key_valid;
  logic [CODE_W-1:0] key_code;
  logic [FILL_W-1:0] fifo_fill;
  logic [DROP_W-1:0] dropped;

  modport source (output valid, output key_valid, output key_code, output fifo_fill,
                  output dropped, input ready);
  modport sink   (input valid, input key_valid, input key_code, input fifo_fill,
                  input dropped, output ready);
endinterface

/* rtl/kdef_ctrl.sv */
// Per-button debounce state: held flags and release timers.
// Depends on kdef_pkg; raises press and release events for the queue.
module kdef_ctrl import kdef_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  cmd_e              cmd_i,
  input  logic [PINS_W-1:0] pins_i,
  input  logic [TMR_W-1:0]  timeout_i,
  output push_req_t         req_o
);

  logic [NUM_BUTTONS-1:0]             held_q, held_d;
  logic [NUM_BUTTONS-1:0][TMR_W-1:0]  tmr_q, tmr_d;
  logic [PINS_W+NUM_BUTTONS-1:0]      pins_wide;
  logic [NUM_BUTTONS-1:0]             pins;

  // Buttons beyond the pin field read as pressed (zero).
  assign pins_wide = {{NUM_BUTTONS{1'b0}}, pins_i};
  assign pins      = pins_wide[NUM_BUTTONS-1:0];

  always_comb begin
    held_d = held_q;
    tmr_d  = tmr_q;
    req_o  = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      case (cmd_i)
        CMD_PIN: begin
          if (!pins[i]) begin
            if (!held_q[i]) begin
              held_d[i]     = 1'b1;
              req_o.push[i] = 1'b1;
            end
          end else if (held_q[i]) begin
            tmr_d[i] = timeout_i;
          end
        end
        CMD_TICK: begin
          req_o.rel = 1'b1;
          if (tmr_q[i] != '0) begin
            tmr_d[i] = tmr_q[i] - TMR_W'(1);
          end else if (pins[i] && held_q[i]) begin
            held_d[i]     = 1'b0;
            req_o.push[i] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      tmr_q  <= '0;
    end else if (fire_i) begin
      held_q <= held_d;
      tmr_q  <= tmr_d;
    end
  end

endmodule

/* rtl/kdef_fifo.sv */
// Event queue: takes up to NUM_BUTTONS pushes per transaction, pops one.
// Depends on kdef_pkg and the assertion macros in the defines header.
`include "key_debounce_event_fifo_defines.svh"

module kdef_fifo import kdef_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              pop_i,
  input  push_req_t         req_i,
  output logic              pop_valid_o,
  output logic [CODE_W-1:0] pop_code_o,
  output logic [CNT_W-1:0]  fill_o,
  output logic [DROP_W-1:0] dropped_o
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [SUM_W-1:0] WRAP = SUM_W'(FIFO_DEPTH);
  localparam int               LOST_W = RANK_W + DROP_W;

  logic [CODE_W-1:0] mem_q [FIFO_DEPTH];
  logic [CODE_W-1:0] pop_code_q;

  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] count_q, count_d, free;

  logic [NUM_BUTTONS-1:0]             push, acc;
  logic [NUM_BUTTONS-1:0][PTR_W-1:0]  addr;
  logic [NUM_BUTTONS-1:0][CODE_W-1:0] code;
  logic [RANK_W-1:0]                  rank, n_acc;
  logic [SUM_W-1:0]                   sum, wp_sum;
  logic [LOST_W-1:0]                  lost;
  logic                               empty_pop, full_hold;

  assign push = fire_i ? req_i.push : '0;
  assign free = FULL - count_q;

  // Rank each push among this transaction's pushes; only ranks below the free
  // space land, at consecutive slots after the write pointer.
  always_comb begin
    rank  = '0;
    n_acc = '0;
    acc   = '0;
    addr  = '0;
    sum   = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      code[i] = {req_i.rel, (CODE_W-1)'(i + 1)};
      sum = SUM_W'(wp_q) + SUM_W'(rank);
      if (sum >= WRAP) begin
        sum = sum - WRAP;
      end
      addr[i] = sum[PTR_W-1:0];
      if (push[i]) begin
        if (SUM_W'(rank) < SUM_W'(free)) begin
          acc[i] = 1'b1;
          n_acc  = n_acc + RANK_W'(1);
        end
        rank = rank + RANK_W'(1);
      end
    end
  end

  always_comb begin
    wp_sum = SUM_W'(wp_q) + SUM_W'(n_acc);
    if (wp_sum >= WRAP) begin
      wp_sum = wp_sum - WRAP;
    end
    wp_d = wp_sum[PTR_W-1:0];
  end

  assign lost      = LOST_W'(rank - n_acc);
  assign dropped_o = (lost > LOST_W'(DROP_MAX)) ? DROP_MAX : lost[DROP_W-1:0];

  assign pop_valid_o = fire_i && pop_i && (count_q != '0);
  assign pop_code_o  = pop_code_q;
  assign rp_d        = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);

  assign count_d = count_q + CNT_W'(n_acc) - CNT_W'(pop_valid_o);
  assign fill_o  = count_d;

  assign empty_pop = fire_i && pop_i && (count_q == '0);
  assign full_hold = fire_i && !pop_i && (count_q == FULL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      wp_q    <= wp_d;
      count_q <= count_d;
      if (pop_valid_o) begin
        rp_q <= rp_d;
      end
    end
  end

  // Register the popped code with its transaction; zero when nothing pops.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (acc[i]) begin
        mem_q[addr[i]] <= code[i];
      end
    end
    if (fire_i) begin
      pop_code_q <= pop_valid_o ? mem_q[rp_q] : '0;
    end
  end

  `KDEF_ASSERT(a_fill_max, 1'b1, count_q <= FULL, "event count above depth")
  `KDEF_ASSERT(a_empty_pop, empty_pop, !pop_valid_o && n_acc == '0, "empty pop returned data")
  `KDEF_ASSERT_NEXT(a_full_hold, full_hold, count_q == FULL && wp_q == $past(wp_q), "full push")

endmodule

/* rtl/key_debounce_event_fifo.sv */
// Top level: four-button debounce feeding a key event queue, one result per item.
// Depends on kdef_pkg, kdef_if, kdef_ctrl and kdef_fifo.
//
//   channel      dir  handshake     payload
//   in_chan_i    in   valid/ready   cmd[1:0], pins[3:0]
//   out_chan_o   out  valid/ready   key_valid, key_code[7:0], fifo_fill[4:0], dropped[2:0]
//   cfg_we_i     in   write enable  cfg_wdata_i[7:0] = release_timeout
//
// Each item is processed in the cycle it is accepted and its result is
// registered; one item per clock unless the sink stalls, result in the cycle after.
// The output register frees in the cycle its result is taken, so input ready
// is low only while a result waits and the sink stalls.
// Reset clears flags, timers, pointers and count; release_timeout resets to 1.
module key_debounce_event_fifo import kdef_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  kdef_in_if.sink          in_chan_i,
  kdef_out_if.source       out_chan_o,
  input  logic             cfg_we_i,
  input  logic [TMR_W-1:0] cfg_wdata_i
);

  logic [TMR_W-1:0]  timeout_q;
  logic              fire;
  cmd_e              cmd;
  push_req_t         req;
  logic              pop_valid;
  logic [CODE_W-1:0] pop_code;
  logic [CNT_W-1:0]  fill;
  logic [DROP_W-1:0] dropped;

  logic              out_valid_q;
  logic              key_valid_q;
  logic [FILL_W-1:0] fill_q;
  logic [DROP_W-1:0] dropped_q;

  assign cmd             = cmd_e'(in_chan_i.cmd);
  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign fire            = in_chan_i.valid && in_chan_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  kdef_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .cmd_i     (cmd),
    .pins_i    (in_chan_i.pins),
    .timeout_i (timeout_q),
    .req_o     (req)
  );

  kdef_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .pop_i       (cmd == CMD_POP),
    .req_i       (req),
    .pop_valid_o (pop_valid),
    .pop_code_o  (pop_code),
    .fill_o      (fill),
    .dropped_o   (dropped)
  );

  // Hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      key_valid_q <= pop_valid;
      fill_q      <= FILL_W'(fill);
      dropped_q   <= dropped;
    end
  end

  assign out_chan_o.valid     = out_valid_q;
  assign out_chan_o.key_valid = key_valid_q;
  assign out_chan_o.key_code  = pop_code;
  assign out_chan_o.fifo_fill = fill_q;
  assign out_chan_o.dropped   = dropped_q;

endmodule

/* tb/tb_key_debounce_event_fifo.sv */
`timescale 1ns / 1ps
// Self-checking testbench for key_debounce_event_fifo: directed rows, then random
// press/hold/release bursts over several release timeouts, checked per result.
// Depends on kdef_pkg, kdef_if and the key_debounce_event_fifo RTL.
module tb_key_debounce_event_fifo;
  import kdef_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [PINS_W-1:0] ALL_UP      = '1;
  localparam logic [PINS_W-1:0] ALL_DOWN    = '0;
  localparam logic [CODE_W-1:0] REL_FLAG    = 8'h80;
  localparam int                CYCLE_LIMIT = 200000;
  localparam int                PHASE_ITEMS = 260;
  localparam int                LONG_HOLD   = 60;
  localparam int                NUM_PHASES  = 5;

  typedef struct packed {
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
    logic [FILL_W-1:0] fifo_fill;
    logic [DROP_W-1:0] dropped;
  } key_result_t;

  typedef struct packed {
    logic        fixed;
    key_result_t res;
  } typed_exp_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PINS_W-1:0] pins;
    typed_exp_t        exp;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we;
  logic [TMR_W-1:0] cfg_wdata;

  kdef_in_if  in_if ();
  kdef_out_if out_if ();

  key_debounce_event_fifo dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic [TMR_W-1:0]       timeout_m;
  logic [NUM_BUTTONS-1:0] held_m;
  logic [TMR_W-1:0]       timer_m [NUM_BUTTONS];
  logic [CODE_W-1:0]      store_m [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_m;
  logic [PTR_W-1:0]       rd_m;
  logic [CNT_W-1:0]       count_m;

  key_result_t expected_keys_q [$];
  typed_exp_t  typed_q [$];
  stim_row_t   directed_q [$];

  int  errors = 0;
  int  cycle_count = 0;
  int  n_items = 0;
  int  n_codes = 0;
  int  n_dropped = 0;
  int  phase_items = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  task automatic enqueue_code(input logic [CODE_W-1:0] code, inout logic [DROP_W-1:0] lost);
    if (count_m >= FIFO_DEPTH) begin
      if (lost != DROP_MAX) lost++;
    end else begin
      store_m[wr_m] = code;
      wr_m = wr_m + 1'b1;
      count_m++;
    end
  endtask

  task automatic debounce_step(input logic [CMD_W-1:0] cmd, input logic [PINS_W-1:0] pins,
                               output key_result_t res);
    logic [DROP_W-1:0] lost;
    int b;
    lost = '0;
    res = '0;
    case (cmd)
      CMD_PIN: begin
        for (b = 0; b < NUM_BUTTONS; b++) begin
          if (!pins[b]) begin
            if (!held_m[b]) begin
              held_m[b] = 1'b1;
              enqueue_code(CODE_W'(b + 1), lost);
            end
          end else if (held_m[b]) begin
            timer_m[b] = timeout_m;
          end
        end
      end
      CMD_TICK: begin
        for (b = 0; b < NUM_BUTTONS; b++) begin
          if (timer_m[b] != '0) begin
            timer_m[b]--;
          end else if (pins[b] && held_m[b]) begin
            held_m[b] = 1'b0;
            enqueue_code(REL_FLAG | CODE_W'(b + 1), lost);
          end
        end
      end
      CMD_POP: begin
        if (count_m != '0) begin
          res.key_valid = 1'b1;
          res.key_code  = store_m[rd_m];
          rd_m = rd_m + 1'b1;
          count_m--;
        end
      end
      default: ;
    endcase
    res.fifo_fill = FILL_W'(count_m);
    res.dropped   = lost;
  endtask

  task automatic check_field(input string name, input int exp, input int got);
    if (exp != got) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp, got);
      errors++;
    end
  endtask

  // Retire results first, then record the transaction accepted at this edge
  always @(posedge clk) begin : scoreboard
    key_result_t got;
    key_result_t want;
    key_result_t pred;
    typed_exp_t  t;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.key_valid = out_if.key_valid;
        got.key_code  = out_if.key_code;
        got.fifo_fill = out_if.fifo_fill;
        got.dropped   = out_if.dropped;
        if (expected_keys_q.size() == 0) begin
          $display("%0t ns: unexpected result: expected none, actual 0x%0h", $time, got);
          errors++;
        end else begin
          want = expected_keys_q.pop_front();
          check_field("key_valid", want.key_valid, got.key_valid);
          check_field("key_code", want.key_code, got.key_code);
          check_field("fifo_fill", want.fifo_fill, got.fifo_fill);
          check_field("dropped", want.dropped, got.dropped);
        end
        if (got.key_valid) n_codes++;
        n_dropped += got.dropped;
      end
      if (in_if.valid && in_if.ready) begin
        debounce_step(in_if.cmd, in_if.pins, pred);
        t = typed_q.pop_front();
        expected_keys_q.push_back(t.fixed ? t.res : pred);
        n_items++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results outstanding", $time, expected_keys_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result sink: random stall per result, plus one long hold on request
  initial begin : key_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (LONG_HOLD) @(negedge clk) out_if.ready <= 1'b0;
      end
      stall = calm ? 0 : $urandom_range(0, 5);
      repeat (stall) @(negedge clk) out_if.ready <= 1'b0;
      @(negedge clk) out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PINS_W-1:0] pins,
                           input typed_exp_t exp = '0);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    typed_q.push_back(exp);
    repeat (gap) @(negedge clk) in_if.valid <= 1'b0;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.pins  <= pins;
    do @(posedge clk); while (!in_if.ready);
    phase_items++;
  endtask

  task automatic drain_results();
    @(negedge clk) in_if.valid <= 1'b0;
    while (expected_keys_q.size() != 0) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic write_timeout(input logic [TMR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    timeout_m = value;
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [PINS_W-1:0] pins,
                         input logic fixed, input logic kv, input logic [CODE_W-1:0] code,
                         input logic [FILL_W-1:0] fill, input logic [DROP_W-1:0] drop);
    stim_row_t row;
    row.cmd = cmd;
    row.pins = pins;
    row.exp.fixed = fixed;
    row.exp.res = '{kv, code, fill, drop};
    directed_q.push_back(row);
  endtask

  // Press, hold, let go, tick out the timeout, then pop; the rest is noise
  task automatic random_burst(input logic [TMR_W-1:0] tmo);
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    calm = ($urandom_range(0, 7) == 0);
    if (kind < 75) begin
      send_item(CMD_PIN, PINS_W'($urandom));
      n = $urandom_range(0, 2);
      repeat (n) send_item(CMD_PIN, PINS_W'($urandom));
      send_item(CMD_PIN, ($urandom_range(0, 3) == 0) ? PINS_W'($urandom) : ALL_UP);
      if (tmo > 8) n = ($urandom_range(0, 3) == 0) ? int'(tmo) + $urandom_range(0, 2)
                                                    : $urandom_range(0, 4);
      else n = $urandom_range(0, int'(tmo) + 2);
      repeat (n) send_item(CMD_TICK, ($urandom_range(0, 4) == 0) ? PINS_W'($urandom) : ALL_UP);
      n = $urandom_range(0, 6);
      repeat (n) send_item(CMD_POP, PINS_W'($urandom));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_item(CMD_W'($urandom_range(0, 3)), PINS_W'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [TMR_W-1:0] tmo;
    stim_row_t row;
    int ph;
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_PIN;
    in_if.pins  = ALL_UP;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    timeout_m   = TIMEOUT_RST;
    held_m      = '0;
    wr_m        = '0;
    rd_m        = '0;
    count_m     = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) timer_m[b] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows; fixed expectations where the answer is obvious
    add_row(CMD_POP,    ALL_UP,   1, 0, 8'h00, 0, 0);  // pop from empty
    add_row(CMD_UNUSED, ALL_DOWN, 1, 0, 8'h00, 0, 0);
    add_row(CMD_TICK,   ALL_UP,   1, 0, 8'h00, 0, 0);
    add_row(CMD_PIN,    ALL_DOWN, 1, 0, 8'h00, 4, 0);  // press all four
    add_row(CMD_POP,    ALL_UP,   1, 1, 8'h01, 3, 0);
    add_row(CMD_PIN,    ALL_UP,   0, 0, 0, 0, 0);
    add_row(CMD_TICK,   ALL_DOWN, 0, 0, 0, 0, 0);
    add_row(CMD_TICK,   ALL_DOWN, 0, 0, 0, 0, 0);      // low buttons stay held
    add_row(CMD_TICK,   ALL_UP,   0, 0, 0, 0, 0);      // release all four
    add_row(CMD_PIN,    4'h5,     0, 0, 0, 0, 0);
    add_row(CMD_PIN,    ALL_DOWN, 0, 0, 0, 0, 0);
    add_row(CMD_PIN,    ALL_UP,   0, 0, 0, 0, 0);
    add_row(CMD_TICK,   ALL_UP,   0, 0, 0, 0, 0);
    add_row(CMD_TICK,   ALL_UP,   0, 0, 0, 0, 0);
    add_row(CMD_PIN,    ALL_DOWN, 0, 0, 0, 0, 0);      // fills up, drops the rest
    add_row(CMD_PIN,    ALL_UP,   0, 0, 0, 0, 0);
    add_row(CMD_TICK,   ALL_UP,   0, 0, 0, 0, 0);
    add_row(CMD_TICK,   ALL_UP,   0, 0, 0, 0, 0);      // releases into a full queue
    add_row(CMD_POP,    ALL_DOWN, 0, 0, 0, 0, 0);
    add_row(CMD_UNUSED, ALL_UP,   0, 0, 0, 0, 0);
    add_row(CMD_POP,    4'hA,     0, 0, 0, 0, 0);
    add_row(CMD_POP,    4'h5,     0, 0, 0, 0, 0);
    add_row(CMD_POP,    ALL_UP,   0, 0, 0, 0, 0);
    foreach (directed_q[i]) begin
      row = directed_q[i];
      send_item(row.cmd, row.pins, row.exp);
    end
    drain_results();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       tmo = '0;
        1:       tmo = TMR_W'($urandom_range(2, 6));
        2:       tmo = '1;
        3:       tmo = TMR_W'($urandom_range(1, 12));
        default: tmo = TIMEOUT_RST;
      endcase
      write_timeout(tmo);
      if (ph == 1) hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        random_burst(tmo);
        // in phase 0, pause the sender after bursts near the middle until everything has come back
        if (ph == 0 && phase_items >= PHASE_ITEMS / 2 && phase_items < PHASE_ITEMS / 2 + 10)
          drain_results();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("Summary: %0d transactions over %0d release timeouts incl. 0 and 255,", n_items,
             NUM_PHASES + 1);
    $display("         %0d key codes popped, %0d events dropped on a full queue", n_codes,
             n_dropped);
    if (errors == 0 && expected_keys_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
